// File: hdl/qo_pkg.sv
// shared types and constants for the quadrature odometry core
`default_nettype none

package qo_pkg;

   // configuration port layout
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_INVERT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_INVERT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_SCALE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_SCALE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROT_SCALE    = 3'd4;

   // register values after reset
   localparam logic [31:0] LEFT_SCALE_RESET  = 32'd1572864;
   localparam logic [31:0] RIGHT_SCALE_RESET = 32'd1572864;
   localparam logic [31:0] ROT_SCALE_RESET   = 32'd12817000;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // controller to datapath commands
   typedef struct packed {
      logic decode;
      logic clear;
      logic latch;
      logic mul_left;
      logic mul_right;
      logic mul_lo;
      logic mul_hi;
      logic load_lm;
      logic load_rm;
      logic load_diff;
      logic load_fwd;
      logic load_plo;
      logic load_rot;
      logic load_out;
   } cmd_type;

endpackage

`default_nettype wire

// File: hdl/qo_mul.sv
// shared 33x32 unsigned multiplier with registered product
`default_nettype none

module qo_mul (
   input  wire                          clock,
   input  wire                          mul_en,
   input  wire  [qo_pkg::MUL_A_W-1:0]   mul_a,
   input  wire  [qo_pkg::MUL_B_W-1:0]   mul_b,
   output logic [qo_pkg::PROD_W-1:0]    prod
);

   logic [qo_pkg::PROD_W-1:0] prod_ff;
   logic [qo_pkg::PROD_W-1:0] prod_in;

   // full-width product
   assign prod_in = qo_pkg::PROD_W'(mul_a) * qo_pkg::PROD_W'(mul_b);

   // product register
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// File: hdl/qo_dpath.sv
// datapath: pin decode, counters, totals, scaling and accumulators
`default_nettype none

module qo_dpath #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  qo_pkg::cmd_type                  cmd,
   // configuration port
   input  wire                              csr_we,
   input  wire  [qo_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [qo_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // input word fields
   input  wire                              req_left_clk,
   input  wire                              req_left_b,
   input  wire                              req_right_clk,
   input  wire                              req_right_b,
   // shared multiplier
   output logic                             mul_en,
   output logic [qo_pkg::MUL_A_W-1:0]       mul_a,
   output logic [qo_pkg::MUL_B_W-1:0]       mul_b,
   input  wire  [qo_pkg::PROD_W-1:0]        prod,
   // result word fields
   output logic signed [15:0]               rsp_left_step_sum,
   output logic signed [15:0]               rsp_right_step_sum,
   output logic signed [31:0]               rsp_left_running,
   output logic signed [31:0]               rsp_right_running,
   output logic signed [31:0]               rsp_fwd_step,
   output logic signed [31:0]               rsp_rot_step,
   output logic signed [47:0]               rsp_distance,
   output logic signed [47:0]               rsp_heading
);

   localparam int FWD_SHIFT = 25 - FRAC_BITS;
   localparam int ROT_SHIFT = 48 - FRAC_BITS;
   localparam int SUM_W     = qo_pkg::PROD_W + 1;
   localparam int MAG_W     = qo_pkg::PROD_W;
   localparam int WIDE_W    = SUM_W + 32;
   localparam int MUL_A_W_L = qo_pkg::MUL_A_W;

   localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
   localparam logic signed [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
   localparam logic [WIDE_W-1:0] SAT_POS = WIDE_W'(32'h7FFF_FFFF);
   localparam logic [WIDE_W-1:0] SAT_NEG = WIDE_W'(32'h8000_0000);

   // one decoded step into a saturating counter
   function automatic logic signed [COUNT_BITS-1:0] count_step(
      input logic signed [COUNT_BITS-1:0] cnt,
      input logic                         prev_a,
      input logic                         prev_b,
      input logic                         new_a,
      input logic                         new_b,
      input logic                         invert
   );
      logic up;
      logic dn;
      logic inc;
      logic dec;
      logic signed [COUNT_BITS-1:0] res;
      up  = prev_a ^ new_b;
      dn  = new_a ^ prev_b;
      inc = invert ? (dn & ~up) : (up & ~dn);
      dec = invert ? (up & ~dn) : (dn & ~up);
      res = cnt;
      if (inc && (cnt != CNT_MAX)) begin
         res = cnt + CNT_ONE;
      end else if (dec && (cnt != CNT_MIN)) begin
         res = cnt - CNT_ONE;
      end
      return res;
   endfunction

   // sign and magnitude to saturated signed 32 bits
   function automatic logic signed [31:0] sat32(
      input logic              neg,
      input logic [WIDE_W-1:0] mag
   );
      logic signed [31:0] res;
      if (!neg) begin
         res = (mag > SAT_POS) ? 32'sh7FFF_FFFF : signed'(mag[31:0]);
      end else begin
         res = (mag >= SAT_NEG) ? 32'sh8000_0000 : signed'(32'(-mag[31:0]));
      end
      return res;
   endfunction

   // configuration registers
   logic        left_invert_ff;
   logic        right_invert_ff;
   logic [31:0] left_scale_ff;
   logic [31:0] right_scale_ff;
   logic [31:0] rot_scale_ff;

   // decoder and count state
   logic left_prev_a_ff,  left_prev_a_in;
   logic left_prev_b_ff,  left_prev_b_in;
   logic right_prev_a_ff, right_prev_a_in;
   logic right_prev_b_ff, right_prev_b_in;
   logic signed [COUNT_BITS-1:0] left_count_ff,  left_count_in;
   logic signed [COUNT_BITS-1:0] right_count_ff, right_count_in;
   logic [31:0] left_sum_ff,  left_sum_in;
   logic [31:0] right_sum_ff, right_sum_in;
   logic [47:0] position_acc_ff, position_acc_in;
   logic [47:0] angle_acc_ff,    angle_acc_in;

   // per-tick working registers
   logic signed [COUNT_BITS-1:0] ld_ff;
   logic signed [COUNT_BITS-1:0] rd_ff;
   logic signed [SUM_W-1:0]      lm_ff;
   logic signed [SUM_W-1:0]      rm_ff;
   logic signed [SUM_W-1:0]      fwd_sum_ff;
   logic [MAG_W-1:0]             dm_ff;
   logic                         dn_ff;
   logic signed [31:0]           fwd_ff;
   logic [63:0]                  plo_ff;
   logic signed [31:0]           rot_ff;

   // result registers
   logic signed [15:0] out_left_step_ff;
   logic signed [15:0] out_right_step_ff;
   logic [31:0]        out_left_sum_ff;
   logic [31:0]        out_right_sum_ff;
   logic signed [31:0] out_fwd_ff;
   logic signed [31:0] out_rot_ff;
   logic [47:0]        out_distance_ff;
   logic [47:0]        out_heading_ff;

   // combinational helpers
   logic                         left_new_a;
   logic                         right_new_a;
   logic signed [COUNT_BITS-1:0] left_cnt_dec;
   logic signed [COUNT_BITS-1:0] right_cnt_dec;
   logic signed [32:0]           ld_wide;
   logic signed [32:0]           rd_wide;
   logic [MUL_A_W_L-1:0]         ld_mag;
   logic [MUL_A_W_L-1:0]         rd_mag;
   logic signed [SUM_W-1:0]      prod_signed;
   logic signed [SUM_W-1:0]      lm_signed;
   logic signed [SUM_W-1:0]      rm_signed;
   logic signed [SUM_W-1:0]      diff_sum;
   logic [SUM_W-1:0]             diff_abs;
   logic [SUM_W-1:0]             fwd_abs;
   logic [MAG_W-1:0]             fwd_shifted;
   logic [SUM_W-1:0]             rot_top;
   logic [WIDE_W-1:0]            rot_full;
   logic [WIDE_W-1:0]            rot_shifted;
   logic [47:0]                  position_add;
   logic [47:0]                  angle_add;

   // pin decode
   assign left_new_a    = req_left_clk ^ req_left_b;
   assign right_new_a   = req_right_clk ^ req_right_b;
   assign left_cnt_dec  = count_step(left_count_ff, left_prev_a_ff, left_prev_b_ff,
                                     left_new_a, req_left_b, left_invert_ff);
   assign right_cnt_dec = count_step(right_count_ff, right_prev_a_ff, right_prev_b_ff,
                                     right_new_a, req_right_b, right_invert_ff);

   // delta magnitudes for the multiplier
   assign ld_wide = 33'(ld_ff);
   assign rd_wide = 33'(rd_ff);
   assign ld_mag  = ld_wide[32] ? 33'(-ld_wide) : 33'(ld_wide);
   assign rd_mag  = rd_wide[32] ? 33'(-rd_wide) : 33'(rd_wide);

   // multiplier operand selection
   always_comb begin
      mul_en = cmd.mul_left | cmd.mul_right | cmd.mul_lo | cmd.mul_hi;
      mul_a  = ld_mag;
      mul_b  = left_scale_ff;
      priority if (cmd.mul_right) begin
         mul_a = rd_mag;
         mul_b = right_scale_ff;
      end else if (cmd.mul_lo) begin
         mul_a = {1'b0, dm_ff[31:0]};
         mul_b = rot_scale_ff;
      end else if (cmd.mul_hi) begin
         mul_a = dm_ff[MAG_W-1:32];
         mul_b = rot_scale_ff;
      end else begin
         mul_a = ld_mag;
         mul_b = left_scale_ff;
      end
   end

   // signed scaled deltas and their combinations
   assign prod_signed = signed'({1'b0, prod});
   assign lm_signed   = ld_ff[COUNT_BITS-1] ? -prod_signed : prod_signed;
   assign rm_signed   = rd_ff[COUNT_BITS-1] ? -prod_signed : prod_signed;
   assign diff_sum    = rm_ff - lm_ff;
   assign diff_abs    = diff_sum[SUM_W-1] ? SUM_W'(-diff_sum) : SUM_W'(diff_sum);

   // forward step: average of the two changes, truncated toward zero
   assign fwd_abs     = fwd_sum_ff[SUM_W-1] ? SUM_W'(-fwd_sum_ff) : SUM_W'(fwd_sum_ff);
   assign fwd_shifted = fwd_abs[MAG_W-1:0] >> FWD_SHIFT;

   // rotation step: wide product assembled from two partial products
   assign rot_top     = SUM_W'(prod) + SUM_W'(plo_ff[63:32]);
   assign rot_full    = {rot_top, plo_ff[31:0]};
   assign rot_shifted = rot_full >> ROT_SHIFT;

   // accumulator sums
   assign position_add = position_acc_ff + 48'(fwd_ff);
   assign angle_add    = angle_acc_ff + 48'(rot_ff);

   // next values of the count state
   always_comb begin
      left_prev_a_in  = left_prev_a_ff;
      left_prev_b_in  = left_prev_b_ff;
      right_prev_a_in = right_prev_a_ff;
      right_prev_b_in = right_prev_b_ff;
      left_count_in   = left_count_ff;
      right_count_in  = right_count_ff;
      left_sum_in     = left_sum_ff;
      right_sum_in    = right_sum_ff;
      position_acc_in = position_acc_ff;
      angle_acc_in    = angle_acc_ff;
      if (cmd.decode) begin
         left_prev_a_in  = left_new_a;
         left_prev_b_in  = req_left_b;
         right_prev_a_in = right_new_a;
         right_prev_b_in = req_right_b;
         left_count_in   = left_cnt_dec;
         right_count_in  = right_cnt_dec;
      end
      priority if (cmd.clear) begin
         left_count_in   = '0;
         right_count_in  = '0;
         left_sum_in     = '0;
         right_sum_in    = '0;
         position_acc_in = '0;
         angle_acc_in    = '0;
      end else if (cmd.latch) begin
         left_count_in  = '0;
         right_count_in = '0;
         left_sum_in    = left_sum_ff + 32'(left_cnt_dec);
         right_sum_in   = right_sum_ff + 32'(right_cnt_dec);
      end else if (cmd.load_out) begin
         position_acc_in = position_add;
         angle_acc_in    = angle_add;
      end else begin
         left_sum_in = left_sum_ff;
      end
   end

   // configuration and count state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_invert_ff  <= 1'b0;
         right_invert_ff <= 1'b0;
         left_scale_ff   <= qo_pkg::LEFT_SCALE_RESET;
         right_scale_ff  <= qo_pkg::RIGHT_SCALE_RESET;
         rot_scale_ff    <= qo_pkg::ROT_SCALE_RESET;
         left_prev_a_ff  <= 1'b0;
         left_prev_b_ff  <= 1'b0;
         right_prev_a_ff <= 1'b0;
         right_prev_b_ff <= 1'b0;
         left_count_ff   <= '0;
         right_count_ff  <= '0;
         left_sum_ff     <= '0;
         right_sum_ff    <= '0;
         position_acc_ff <= '0;
         angle_acc_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               qo_pkg::CSR_LEFT_INVERT:  left_invert_ff  <= csr_wdata[0];
               qo_pkg::CSR_RIGHT_INVERT: right_invert_ff <= csr_wdata[0];
               qo_pkg::CSR_LEFT_SCALE:   left_scale_ff   <= csr_wdata;
               qo_pkg::CSR_RIGHT_SCALE:  right_scale_ff  <= csr_wdata;
               qo_pkg::CSR_ROT_SCALE:    rot_scale_ff    <= csr_wdata;
               default: ;
            endcase
         end
         left_prev_a_ff  <= left_prev_a_in;
         left_prev_b_ff  <= left_prev_b_in;
         right_prev_a_ff <= right_prev_a_in;
         right_prev_b_ff <= right_prev_b_in;
         left_count_ff   <= left_count_in;
         right_count_ff  <= right_count_in;
         left_sum_ff     <= left_sum_in;
         right_sum_ff    <= right_sum_in;
         position_acc_ff <= position_acc_in;
         angle_acc_ff    <= angle_acc_in;
      end
   end

   // per-tick working registers and result word
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         ld_ff <= left_cnt_dec;
         rd_ff <= right_cnt_dec;
      end
      if (cmd.load_lm) begin
         lm_ff <= lm_signed;
      end
      if (cmd.load_rm) begin
         rm_ff <= rm_signed;
      end
      if (cmd.load_diff) begin
         fwd_sum_ff <= lm_ff + rm_ff;
         dm_ff      <= diff_abs[MAG_W-1:0];
         dn_ff      <= diff_sum[SUM_W-1];
      end
      if (cmd.load_fwd) begin
         fwd_ff <= sat32(fwd_sum_ff[SUM_W-1], WIDE_W'(fwd_shifted));
      end
      if (cmd.load_plo) begin
         plo_ff <= prod[63:0];
      end
      if (cmd.load_rot) begin
         rot_ff <= sat32(dn_ff, rot_shifted);
      end
      if (cmd.load_out) begin
         out_left_step_ff  <= signed'(ld_wide[15:0]);
         out_right_step_ff <= signed'(rd_wide[15:0]);
         out_left_sum_ff   <= left_sum_ff;
         out_right_sum_ff  <= right_sum_ff;
         out_fwd_ff        <= fwd_ff;
         out_rot_ff        <= rot_ff;
         out_distance_ff   <= position_add;
         out_heading_ff    <= angle_add;
      end
   end

   assign rsp_left_step_sum  = out_left_step_ff;
   assign rsp_right_step_sum = out_right_step_ff;
   assign rsp_left_running   = signed'(out_left_sum_ff);
   assign rsp_right_running  = signed'(out_right_sum_ff);
   assign rsp_fwd_step       = out_fwd_ff;
   assign rsp_rot_step       = out_rot_ff;
   assign rsp_distance       = signed'(out_distance_ff);
   assign rsp_heading        = signed'(out_heading_ff);

endmodule

`default_nettype wire

// File: hdl/qo_ctrl.sv
// controller: input word handshake, tick sequence and result word valid
`default_nettype none

module qo_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire              req_tick,
   input  wire              req_clear_all,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output qo_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_L,
      ST_MUL_R,
      ST_LOAD_R,
      ST_COMBINE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ROTATE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.decode = accept;
            cmd.clear  = accept & req_clear_all;
            cmd.latch  = accept & ~req_clear_all & req_tick;
            if (cmd.latch) begin
               state_in = ST_MUL_L;
            end
         end
         ST_MUL_L: begin
            cmd.mul_left = 1'b1;
            state_in     = ST_MUL_R;
         end
         ST_MUL_R: begin
            cmd.mul_right = 1'b1;
            cmd.load_lm   = 1'b1;
            state_in      = ST_LOAD_R;
         end
         ST_LOAD_R: begin
            cmd.load_rm = 1'b1;
            state_in    = ST_COMBINE;
         end
         ST_COMBINE: begin
            cmd.load_diff = 1'b1;
            state_in      = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo   = 1'b1;
            cmd.load_fwd = 1'b1;
            state_in     = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi   = 1'b1;
            cmd.load_plo = 1'b1;
            state_in     = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.load_rot = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a result word only appears out of the final state
   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside the final state");

   // a tick word starts the multiply sequence
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> (state_ff == ST_MUL_L))
      else $error("tick word did not start the sequence");

   // clear never starts the multiply sequence
   a_clear_no_seq: assert property (@(posedge clock) disable iff (reset)
      (accept && req_clear_all) |=> (state_ff == ST_IDLE))
      else $error("clear word started the sequence");

   // a finished result waits while the output is held
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=>
         (state_ff == ST_DONE && rsp_valid_ff))
      else $error("finished result overwrote a held word");

endmodule

`default_nettype wire

// File: hdl/quadrature_odometry_core.sv
// top level: quadrature decoder pair with differential odometry
// latency: a word without tick (or with clear) is absorbed in its accept cycle
// states MUL_L, MUL_R, LOAD_R, COMBINE, MUL_LO, MUL_HI, ROTATE and DONE follow a tick word
// its result word is loaded out of DONE once the output is free; input stalls until back in IDLE
// a finished result waits in the output register while the next words are accepted
// reset: synchronous, zeroes pins, counters, totals, accumulators; scales take defaults
`default_nettype none

module quadrature_odometry_core #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   // configuration port
   input  wire                              csr_we,
   input  wire  [qo_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [qo_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // input words
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_left_clk,
   input  wire                              req_left_b,
   input  wire                              req_right_clk,
   input  wire                              req_right_b,
   input  wire                              req_tick,
   input  wire                              req_clear_all,
   // result words
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic signed [15:0]               rsp_left_step_sum,
   output logic signed [15:0]               rsp_right_step_sum,
   output logic signed [31:0]               rsp_left_running,
   output logic signed [31:0]               rsp_right_running,
   output logic signed [31:0]               rsp_fwd_step,
   output logic signed [31:0]               rsp_rot_step,
   output logic signed [47:0]               rsp_distance,
   output logic signed [47:0]               rsp_heading
);

   qo_pkg::cmd_type                  cmd;
   logic                             mul_en;
   logic [qo_pkg::MUL_A_W-1:0]       mul_a;
   logic [qo_pkg::MUL_B_W-1:0]       mul_b;
   logic [qo_pkg::PROD_W-1:0]        prod;

   // sequence control
   qo_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_tick      (req_tick),
      .req_clear_all (req_clear_all),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd)
   );

   // decode, scaling and accumulation
   qo_dpath #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_left_clk       (req_left_clk),
      .req_left_b         (req_left_b),
      .req_right_clk      (req_right_clk),
      .req_right_b        (req_right_b),
      .mul_en             (mul_en),
      .mul_a              (mul_a),
      .mul_b              (mul_b),
      .prod               (prod),
      .rsp_left_step_sum  (rsp_left_step_sum),
      .rsp_right_step_sum (rsp_right_step_sum),
      .rsp_left_running   (rsp_left_running),
      .rsp_right_running  (rsp_right_running),
      .rsp_fwd_step       (rsp_fwd_step),
      .rsp_rot_step       (rsp_rot_step),
      .rsp_distance       (rsp_distance),
      .rsp_heading        (rsp_heading)
   );

   // shared multiplier
   qo_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod   (prod)
   );

endmodule

`default_nettype wire
